// ----- rtl/bpap_pkg.sv -----
// ----------------------------------------------------------------------------
// bpap_pkg
// Shared types and constants for the Bezier anti-aliased point plotter.
// ----------------------------------------------------------------------------
package bpap_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 1024;
  localparam int T_FRAC_BITS  = 16;

  localparam int COORD_W   = 10;
  localparam int PARAM_W   = 16;
  localparam int INT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int DSQ_W     = 35;  // squared distance, 32 fraction bits
  localparam int NORM_FRAC = 32;
  localparam int LIM_W     = DSQ_W + 16;
  localparam int SQ_W      = 16;  // k^2 for k < 256

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
    REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0][COORD_W-1:0] x;
    logic [3:0][COORD_W-1:0] y;
  } ctrl_pts_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic signed [1:0]  dr;
    logic signed [1:0]  dc;
    logic               last;
  } pix_tag_t;

endpackage

// ----- rtl/bpap_curve.sv -----
// ----------------------------------------------------------------------------
// bpap_curve
// Four-stage de Casteljau pipeline: three lerp rounds, then pixel setup
// (own pixel, neighborhood offsets, in-frame mask).
// ----------------------------------------------------------------------------
module bpap_curve #(
  parameter int FRAME_WIDTH  = bpap_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = bpap_pkg::FRAME_HEIGHT,
  parameter int T_FRAC_BITS  = bpap_pkg::T_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpap_pkg::ctrl_pts_t              pts_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bpap_pkg::PARAM_W-1:0]     param_t_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bpap_pkg::COORD_W-1:0]     row_o,
  output logic [bpap_pkg::COORD_W-1:0]     col_o,
  output logic [T_FRAC_BITS-1:0]           fy_o,
  output logic [T_FRAC_BITS-1:0]           fx_o,
  output logic                             off_y_o,
  output logic                             off_x_o,
  output logic [3:0]                       mask_o
);

  localparam int F  = T_FRAC_BITS;
  localparam int PW = bpap_pkg::COORD_W + F;
  localparam int MW = PW + F + 2;
  localparam logic signed [13:0] FH = 14'(FRAME_HEIGHT);
  localparam logic signed [13:0] FW = 14'(FRAME_WIDTH);

  function automatic logic [PW-1:0] lerp(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                         input logic [F-1:0] t);
    logic signed [PW:0]   diff;
    logic signed [MW-1:0] prod;
    logic signed [MW-1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = MW'(diff) * $signed({1'b0, t});
    sum  = $signed({{(MW-PW){1'b0}}, a}) + (prod >>> F);
    return sum[PW-1:0];
  endfunction

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;
  logic [F-1:0] t_in, t1_q, t2_q;
  logic [2:0][PW-1:0] ax_q, ay_q;
  logic [1:0][PW-1:0] bx_q, by_q;
  logic [PW-1:0] px_q, py_q;

  logic [bpap_pkg::COORD_W-1:0] row_d, col_d, row_q, col_q;
  logic [F-1:0] fy_d, fx_d, fy_q, fx_q;
  logic off_y_d, off_x_d, off_y_q, off_x_q;
  logic [3:0] mask_d, mask_q;
  logic signed [13:0] rb, cb;
  logic [1:0] rok, cok;

  assign t_in = F'({{F{1'b0}}, param_t_i});

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= t_in;
      for (int i = 0; i < 3; i++) begin
        ax_q[i] <= lerp({pts_i.x[i], {F{1'b0}}}, {pts_i.x[i+1], {F{1'b0}}}, t_in);
        ay_q[i] <= lerp({pts_i.y[i], {F{1'b0}}}, {pts_i.y[i+1], {F{1'b0}}}, t_in);
      end
    end
    if (en2) begin
      t2_q <= t1_q;
      for (int i = 0; i < 2; i++) begin
        bx_q[i] <= lerp(ax_q[i], ax_q[i+1], t1_q);
        by_q[i] <= lerp(ay_q[i], ay_q[i+1], t1_q);
      end
    end
    if (en3) begin
      px_q <= lerp(bx_q[0], bx_q[1], t2_q);
      py_q <= lerp(by_q[0], by_q[1], t2_q);
    end
    if (en4) begin
      row_q   <= row_d;
      col_q   <= col_d;
      fy_q    <= fy_d;
      fx_q    <= fx_d;
      off_y_q <= off_y_d;
      off_x_q <= off_x_d;
      mask_q  <= mask_d;
    end
  end

  always_comb begin
    row_d   = py_q[PW-1:F];
    col_d   = px_q[PW-1:F];
    fy_d    = py_q[F-1:0];
    fx_d    = px_q[F-1:0];
    off_y_d = !fy_d[F-1];
    off_x_d = !fx_d[F-1];
    rb = $signed({4'b0, row_d}) - $signed({13'b0, off_y_d});
    cb = $signed({4'b0, col_d}) - $signed({13'b0, off_x_d});
    for (int i = 0; i < 2; i++) begin
      rok[i] = (rb + 14'(i) >= 0) && (rb + 14'(i) < FH);
      cok[i] = (cb + 14'(i) >= 0) && (cb + 14'(i) < FW);
    end
    for (int i = 0; i < 4; i++) begin
      mask_d[i] = rok[i/2] && cok[i%2];
    end
  end

  assign out_valid_o = v4_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign fy_o    = fy_q;
  assign fx_o    = fx_q;
  assign off_y_o = off_y_q;
  assign off_x_o = off_x_q;
  assign mask_o  = mask_q;

endmodule

// ----- rtl/bpap_expand.sv -----
// ----------------------------------------------------------------------------
// bpap_expand
// Walks the 2x2 neighborhood of one point, one slot per cycle unless the output stalls, rows outer.
// ----------------------------------------------------------------------------
module bpap_expand #(
  parameter int T_FRAC_BITS = bpap_pkg::T_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bpap_pkg::COORD_W-1:0] row_i,
  input  logic [bpap_pkg::COORD_W-1:0] col_i,
  input  logic [T_FRAC_BITS-1:0]       fy_i,
  input  logic [T_FRAC_BITS-1:0]       fx_i,
  input  logic                         off_y_i,
  input  logic                         off_x_i,
  input  logic [3:0]                   mask_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bpap_pkg::pix_tag_t           tag_o,
  output logic [T_FRAC_BITS-1:0]       fy_o,
  output logic [T_FRAC_BITS-1:0]       fx_o
);

  logic busy_q;
  logic [1:0] slot_q;
  logic [bpap_pkg::COORD_W-1:0] row_q, col_q;
  logic [T_FRAC_BITS-1:0] fy_q, fx_q;
  logic off_y_q, off_x_q;
  logic [3:0] mask_q, above;
  logic adv, done, take;

  assign adv  = busy_q && (!mask_q[slot_q] || out_ready_i);
  assign done = adv && (slot_q == 2'd3);
  assign in_ready_o = !busy_q || done;
  assign take = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= 2'd0;
    end else if (take) begin
      busy_q <= (mask_i != 4'd0);
      slot_q <= 2'd0;
    end else if (adv) begin
      slot_q <= slot_q + 2'd1;
      if (done) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q   <= row_i;
      col_q   <= col_i;
      fy_q    <= fy_i;
      fx_q    <= fx_i;
      off_y_q <= off_y_i;
      off_x_q <= off_x_i;
      mask_q  <= mask_i;
    end
  end

  always_comb begin
    above = mask_q >> slot_q;
    tag_o.row  = row_q - bpap_pkg::COORD_W'(off_y_q) + bpap_pkg::COORD_W'(slot_q[1]);
    tag_o.col  = col_q - bpap_pkg::COORD_W'(off_x_q) + bpap_pkg::COORD_W'(slot_q[0]);
    tag_o.dr   = $signed({1'b0, slot_q[1]}) - $signed({1'b0, off_y_q});
    tag_o.dc   = $signed({1'b0, slot_q[0]}) - $signed({1'b0, off_x_q});
    tag_o.last = (above[3:1] == 3'd0);
  end

  assign out_valid_o = busy_q && mask_q[slot_q];
  assign fy_o = fy_q;
  assign fx_o = fx_q;

endmodule

// ----- rtl/bpap_shade.sv -----
// ----------------------------------------------------------------------------
// bpap_shade
// Per-pixel pipeline: squared distances, limit product, then one intensity
// bit per stage (MSB first). Last stage is the output register.
// ----------------------------------------------------------------------------
module bpap_shade #(
  parameter int T_FRAC_BITS = bpap_pkg::T_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bpap_pkg::pix_tag_t           tag_i,
  input  logic [T_FRAC_BITS-1:0]       fy_i,
  input  logic [T_FRAC_BITS-1:0]       fx_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bpap_pkg::COORD_W-1:0] pixel_row_o,
  output logic [bpap_pkg::COORD_W-1:0] pixel_col_o,
  output logic [bpap_pkg::INT_W-1:0]   intensity_o,
  output logic                         last_o
);

  localparam int F     = T_FRAC_BITS;
  localparam int DW    = F + 3;
  localparam int RAW_W = 2 * F + 3;
  localparam int WW    = RAW_W + bpap_pkg::NORM_FRAC;
  localparam int NB    = bpap_pkg::INT_W;
  localparam int DSQ_W = bpap_pkg::DSQ_W;
  localparam int LIM_W = bpap_pkg::LIM_W;
  localparam int SQ_W  = bpap_pkg::SQ_W;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (F - 1);
  localparam logic [SQ_W-1:0] K_SCALE = SQ_W'(65025);

  function automatic logic [DSQ_W-1:0] norm(input logic signed [DW-1:0] dy,
                                            input logic signed [DW-1:0] dx);
    logic [2*DW-1:0] sy, sx;
    logic [RAW_W-1:0] raw;
    logic [WW-1:0] wide;
    sy   = dy * dy;
    sx   = dx * dx;
    raw  = RAW_W'(sy) + RAW_W'(sx);
    wide = {raw, {bpap_pkg::NORM_FRAC{1'b0}}} >> (2 * F);
    return wide[DSQ_W-1:0];
  endfunction

  logic signed [DW-1:0] dy, dx, dy0, dx0;

  logic en1, en2;
  logic v1_q, v2_q;
  bpap_pkg::pix_tag_t tag1_q, tag2_q;
  logic [DSQ_W-1:0] dsq1_q, d0sq1_q, dsq2_q;
  logic [LIM_W-1:0] lim2_q;

  logic             sen    [NB];
  logic             sv_q   [NB];
  bpap_pkg::pix_tag_t stag_q [NB];
  logic [DSQ_W-1:0] sdsq_q [NB];
  logic [LIM_W-1:0] slim_q [NB];
  logic [NB-1:0]    sk_q   [NB];
  logic [SQ_W-1:0]  sksq_q [NB];

  always_comb begin
    dy0 = $signed({3'b0, fy_i}) - HALF;
    dx0 = $signed({3'b0, fx_i}) - HALF;
    dy  = dy0 - (DW'(tag_i.dr) <<< F);
    dx  = dx0 - (DW'(tag_i.dc) <<< F);
  end

  assign en2 = !v2_q || sen[0];
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tag1_q  <= tag_i;
      dsq1_q  <= norm(dy, dx);
      d0sq1_q <= norm(dy0, dx0);
    end
    if (en2) begin
      tag2_q <= tag1_q;
      dsq2_q <= dsq1_q;
      lim2_q <= LIM_W'(K_SCALE) * LIM_W'(d0sq1_q);
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_bit
    localparam int B = NB - 1 - s;
    logic v_in;
    bpap_pkg::pix_tag_t tag_in;
    logic [DSQ_W-1:0] dsq_in;
    logic [LIM_W-1:0] lim_in;
    logic [NB-1:0]    k_in;
    logic [SQ_W-1:0]  ksq_in;
    logic [SQ_W:0]    cand2;
    logic [LIM_W-1:0] prod;
    logic             hit;

    if (s == 0) begin : g_first
      assign v_in   = v2_q;
      assign tag_in = tag2_q;
      assign dsq_in = dsq2_q;
      assign lim_in = lim2_q;
      assign k_in   = '0;
      assign ksq_in = '0;
    end else begin : g_next
      assign v_in   = sv_q[s-1];
      assign tag_in = stag_q[s-1];
      assign dsq_in = sdsq_q[s-1];
      assign lim_in = slim_q[s-1];
      assign k_in   = sk_q[s-1];
      assign ksq_in = sksq_q[s-1];
    end

    if (s == NB - 1) begin : g_end
      assign sen[s] = !sv_q[s] || out_ready_i;
    end else begin : g_mid
      assign sen[s] = !sv_q[s] || sen[s+1];
    end

    assign cand2 = (SQ_W + 1)'(ksq_in) + ((SQ_W + 1)'(k_in) << (B + 1))
                 + ((SQ_W + 1)'(1) << (2 * B));
    assign prod  = LIM_W'(cand2[SQ_W-1:0]) * LIM_W'(dsq_in);
    assign hit   = (prod <= lim_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s] <= 1'b0;
      end else if (sen[s]) begin
        sv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sen[s]) begin
        stag_q[s] <= tag_in;
        sdsq_q[s] <= dsq_in;
        slim_q[s] <= lim_in;
        sk_q[s]   <= hit ? (k_in | (NB'(1) << B)) : k_in;
        sksq_q[s] <= hit ? cand2[SQ_W-1:0] : ksq_in;
      end
    end
  end

  assign out_valid_o = sv_q[NB-1];
  assign pixel_row_o = stag_q[NB-1].row;
  assign pixel_col_o = stag_q[NB-1].col;
  assign intensity_o = sk_q[NB-1];
  assign last_o      = stag_q[NB-1].last;

endmodule

// ----- rtl/bezier_point_antialias_plot_top.sv -----
// ----------------------------------------------------------------------------
// bezier_point_antialias_plot_top
// Cubic Bezier point evaluation with anti-aliased 2x2 pixel writes.
// ----------------------------------------------------------------------------
// Each accepted t yields zero to four pixel writes, one per cycle unless the
// output stalls, the final one flagged by last. The expander steps through
// all four slots of a t with any pixel in frame before it takes the next t;
// a t with no pixel in frame passes at one per cycle. A t reaches its first
// write through four curve stages, the expander, two distance stages and
// eight intensity bit stages. Control points must be written through the
// config port only while the block is idle; the block does not enforce this.
module bezier_point_antialias_plot_top #(
  parameter int FRAME_WIDTH  = bpap_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = bpap_pkg::FRAME_HEIGHT,
  parameter int T_FRAC_BITS  = bpap_pkg::T_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpap_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpap_pkg::COORD_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bpap_pkg::PARAM_W-1:0]   param_t_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bpap_pkg::COORD_W-1:0]   pixel_row_o,
  output logic [bpap_pkg::COORD_W-1:0]   pixel_col_o,
  output logic [bpap_pkg::INT_W-1:0]     intensity_o,
  output logic                           last_o
);

  bpap_pkg::ctrl_pts_t pts_q;

  logic c_valid, c_ready;
  logic [bpap_pkg::COORD_W-1:0] c_row, c_col;
  logic [T_FRAC_BITS-1:0] c_fy, c_fx, e_fy, e_fx;
  logic c_off_y, c_off_x;
  logic [3:0] c_mask;
  logic e_valid, e_ready;
  bpap_pkg::pix_tag_t e_tag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (bpap_pkg::cfg_reg_e'(cfg_index_i))
        bpap_pkg::REG_P0_X: pts_q.x[0] <= cfg_data_i;
        bpap_pkg::REG_P0_Y: pts_q.y[0] <= cfg_data_i;
        bpap_pkg::REG_P1_X: pts_q.x[1] <= cfg_data_i;
        bpap_pkg::REG_P1_Y: pts_q.y[1] <= cfg_data_i;
        bpap_pkg::REG_P2_X: pts_q.x[2] <= cfg_data_i;
        bpap_pkg::REG_P2_Y: pts_q.y[2] <= cfg_data_i;
        bpap_pkg::REG_P3_X: pts_q.x[3] <= cfg_data_i;
        bpap_pkg::REG_P3_Y: pts_q.y[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpap_curve #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_curve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pts_i      (pts_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .param_t_i  (param_t_i),
    .out_valid_o(c_valid),
    .out_ready_i(c_ready),
    .row_o      (c_row),
    .col_o      (c_col),
    .fy_o       (c_fy),
    .fx_o       (c_fx),
    .off_y_o    (c_off_y),
    .off_x_o    (c_off_x),
    .mask_o     (c_mask)
  );

  bpap_expand #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_expand (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (c_valid),
    .in_ready_o (c_ready),
    .row_i      (c_row),
    .col_i      (c_col),
    .fy_i       (c_fy),
    .fx_i       (c_fx),
    .off_y_i    (c_off_y),
    .off_x_i    (c_off_x),
    .mask_i     (c_mask),
    .out_valid_o(e_valid),
    .out_ready_i(e_ready),
    .tag_o      (e_tag),
    .fy_o       (e_fy),
    .fx_o       (e_fx)
  );

  bpap_shade #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_shade (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (e_valid),
    .in_ready_o (e_ready),
    .tag_i      (e_tag),
    .fy_i       (e_fy),
    .fx_i       (e_fx),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_row_o(pixel_row_o),
    .pixel_col_o(pixel_col_o),
    .intensity_o(intensity_o),
    .last_o     (last_o)
  );

endmodule

// ----- rtl/bpap_checker.sv -----
// ----------------------------------------------------------------------------
// bpap_checker
// Port-level checks for the Bezier anti-aliased point plotter.
// ----------------------------------------------------------------------------
module bpap_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [bpap_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [bpap_pkg::COORD_W-1:0]   cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [bpap_pkg::PARAM_W-1:0]   param_t_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bpap_pkg::COORD_W-1:0]   pixel_row_o,
  input logic [bpap_pkg::COORD_W-1:0]   pixel_col_o,
  input logic [bpap_pkg::INT_W-1:0]     intensity_o,
  input logic                           last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_row_o)
      && $stable(pixel_col_o) && $stable(intensity_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind bezier_point_antialias_plot_top bpap_checker u_bpap_checker (.*);

// ----- tb/sv/tb_bezier_point_antialias_plot_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_point_antialias_plot_top
// Self-checking bench for the Bezier anti-aliased point plotter. Control
// points are set through the config port while idle, curve parameters are
// streamed with random gaps and output back-pressure, and every pixel write
// is compared field by field against a table entry or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_bezier_point_antialias_plot_top;

  typedef struct {
    logic [bpap_pkg::COORD_W-1:0] row;
    logic [bpap_pkg::COORD_W-1:0] col;
    logic [bpap_pkg::INT_W-1:0]   inten;
    logic                         last;
  } pix_t;

  typedef struct {
    logic                         is_cfg;
    bpap_pkg::cfg_reg_e           idx;
    logic [bpap_pkg::COORD_W-1:0] data;
    logic [bpap_pkg::PARAM_W-1:0] t;
    logic                         typed;
    pix_t                         want;
  } vec_t;

  localparam int DRAIN_CYC = 40;
  localparam int WDOG_LIM  = 5000;
  localparam int N_RAND    = 250;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [bpap_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bpap_pkg::COORD_W-1:0]   cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [bpap_pkg::PARAM_W-1:0] param_t_i;
  logic out_valid_o, out_ready_i;
  logic [bpap_pkg::COORD_W-1:0] pixel_row_o, pixel_col_o;
  logic [bpap_pkg::INT_W-1:0]   intensity_o;
  logic last_o;

  bezier_point_antialias_plot_top dut (.*);

  logic [bpap_pkg::COORD_W-1:0] ctl_x [4];
  logic [bpap_pkg::COORD_W-1:0] ctl_y [4];
  pix_t pending_px [$];
  int errors, n_items, n_pix, n_cfg, idle_cyc;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_expected(pix_t p);
    pending_px = {pending_px, p};
  endfunction

  function automatic longint lerp_pt(longint a, longint b, longint t);
    return (a * (65536 - t) + b * t) >>> 16;
  endfunction

  function automatic longint curve_pt(longint c0, longint c1, longint c2, longint c3,
                                      longint t);
    longint a0, a1, a2;
    a0 = lerp_pt(c0 << 16, c1 << 16, t);
    a1 = lerp_pt(c1 << 16, c2 << 16, t);
    a2 = lerp_pt(c2 << 16, c3 << 16, t);
    return lerp_pt(lerp_pt(a0, a1, t), lerp_pt(a1, a2, t), t);
  endfunction

  function automatic longint center_dsq(longint py, longint px, longint r, longint c);
    longint dy, dx;
    dy = py - r * 65536 - 32768;
    dx = px - c * 65536 - 32768;
    return dy * dy + dx * dx;
  endfunction

  function automatic int brightness(longint d0sq, longint dsq);
    longint lim, k, cand;
    if (dsq == 0) return 255;
    lim = 65025 * d0sq;
    k = 0;
    for (int b = 7; b >= 0; b--) begin
      cand = k | (longint'(1) << b);
      if (cand * cand * dsq <= lim) k = cand;
    end
    return int'(k);
  endfunction

  task automatic predict_pixels(logic [bpap_pkg::PARAM_W-1:0] t);
    longint px, py, row, col, r0, c0, d0;
    pix_t p;
    int n;
    px = curve_pt(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], t);
    py = curve_pt(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], t);
    row = py >>> 16;
    col = px >>> 16;
    r0 = (py[15:0] < 16'h8000) ? row - 1 : row;
    c0 = (px[15:0] < 16'h8000) ? col - 1 : col;
    d0 = center_dsq(py, px, row, col);
    n = 0;
    for (longint r = r0; r <= r0 + 1; r++)
      for (longint c = c0; c <= c0 + 1; c++) begin
        if (r < 0 || c < 0 || r >= bpap_pkg::FRAME_HEIGHT || c >= bpap_pkg::FRAME_WIDTH)
          continue;
        p.row = r[bpap_pkg::COORD_W-1:0];
        p.col = c[bpap_pkg::COORD_W-1:0];
        p.inten = bpap_pkg::INT_W'(brightness(d0, center_dsq(py, px, r, c)));
        p.last = 1'b0;
        add_expected(p);
        n++;
      end
    if (n > 0) pending_px[pending_px.size()-1].last = 1'b1;
  endtask

  task automatic send_param(logic [bpap_pkg::PARAM_W-1:0] t, bit typed, pix_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    param_t_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) add_expected(want);
    else predict_pixels(t);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_px.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(bpap_pkg::cfg_reg_e idx, logic [bpap_pkg::COORD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx[0]) ctl_y[idx[2:1]] = val;
    else ctl_x[idx[2:1]] = val;
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    pix_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_pix++;
      if (pending_px.size() == 0) begin
        $error("pixel write with nothing expected: row %0d col %0d",
               pixel_row_o, pixel_col_o);
        errors++;
      end else begin
        e = pending_px.pop_front();
        if (pixel_row_o !== e.row) begin
          $error("pixel_row exp %0d got %0d", e.row, pixel_row_o); errors++;
        end
        if (pixel_col_o !== e.col) begin
          $error("pixel_col exp %0d got %0d", e.col, pixel_col_o); errors++;
        end
        if (intensity_o !== e.inten) begin
          $error("intensity exp %0d got %0d", e.inten, intensity_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIM) begin
      $display("timeout: no transfer for %0d cycles", WDOG_LIM);
      $display("bezier_point_antialias_plot_top: mismatch");
      $finish;
    end
  end

  vec_t dir_tab [];
  pix_t corner;

  initial begin
    corner = '{row: 0, col: 0, inten: 255, last: 1'b1};
    dir_tab = '{
      '{0, bpap_pkg::REG_P0_X, 0, 16'h0000, 1, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'hFFFF, 1, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h8000, 1, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h5A5A, 1, corner},
      '{1, bpap_pkg::REG_P0_X, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P0_Y, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P1_X, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P1_Y, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P2_X, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P2_Y, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P3_X, 1023, 0, 0, corner},
      '{1, bpap_pkg::REG_P3_Y, 1023, 0, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h0000, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'hFFFF, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h7FFF, 0, corner},
      '{1, bpap_pkg::REG_P0_X, 0, 0, 0, corner},
      '{1, bpap_pkg::REG_P1_Y, 0, 0, 0, corner},
      '{1, bpap_pkg::REG_P2_X, 0, 0, 0, corner},
      '{1, bpap_pkg::REG_P3_Y, 3, 0, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h0000, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h0001, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h4000, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h8000, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'hC000, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'hFFFF, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'hAAAA, 0, corner},
      '{0, bpap_pkg::REG_P0_X, 0, 16'h5555, 0, corner}
    };
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; param_t_i = '0;
    errors = 0; n_items = 0; n_pix = 0; n_cfg = 0; idle_cyc = 0;
    hold_req = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ctl_x[i] = '0;
      ctl_y[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (in_valid_i || pending_px.size() > 0) drain();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else
        send_param(dir_tab[i].t, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int i = 0; i < N_RAND; i++) begin
      if (i % 50 == 0) begin
        drain();
        for (int r = 0; r < 8; r++)
          case ($urandom_range(0, 3))
            0: write_reg(bpap_pkg::cfg_reg_e'(r),
                         bpap_pkg::COORD_W'($urandom_range(0, 2)));
            1: write_reg(bpap_pkg::cfg_reg_e'(r),
                         bpap_pkg::COORD_W'($urandom_range(1021, 1023)));
            default: write_reg(bpap_pkg::cfg_reg_e'(r),
                               bpap_pkg::COORD_W'($urandom_range(0, 1023)));
          endcase
      end
      if (i == 120) hold_req = 1'b1;
      send_param(bpap_pkg::PARAM_W'($urandom_range(0, 16'hFFFF)), 1'b0, corner);
    end
    drain();

    $display("%0d parameters, %0d pixel writes, %0d register writes checked",
             n_items, n_pix, n_cfg);
    if (errors == 0)
      $display("bezier_point_antialias_plot_top: match");
    else
      $display("bezier_point_antialias_plot_top: mismatch");
    $finish;
  end

endmodule

// ----- bezier_point_antialias_plot_top.f -----
rtl/bpap_pkg.sv
rtl/bpap_curve.sv
rtl/bpap_expand.sv
rtl/bpap_shade.sv
rtl/bezier_point_antialias_plot_top.sv
rtl/bpap_checker.sv
tb/sv/tb_bezier_point_antialias_plot_top.sv
